FILE: hw/rtl/chpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chpi_pkg
// Shared types and codes for the CH-pi contact test pipeline.
// ----------------------------------------------------------------------------
package chpi_pkg;

  typedef logic [1:0] verdict_t;

  localparam verdict_t VERDICT_HIT    = 2'd0;
  localparam verdict_t VERDICT_FAR    = 2'd1;
  localparam verdict_t VERDICT_ANGLE  = 2'd2;
  localparam verdict_t VERDICT_WINDOW = 2'd3;

  localparam logic [1:0] REG_REACH = 2'd0;
  localparam logic [1:0] REG_COS   = 2'd1;
  localparam logic [1:0] REG_WLOW  = 2'd2;
  localparam logic [1:0] REG_WHIGH = 2'd3;

  localparam int CFG_W = 16;
  localparam int IDX_W = 2;

  // Rounding offset and shift for the projection (frac F+28 back to F).
  localparam int PROJ_SHIFT = 28;

endpackage

FILE: hw/rtl/ch_pi_contact_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ch_pi_contact_test
// Reach, C-H-centre angle and in-plane window tests for one ring/CH pair.
// ----------------------------------------------------------------------------
// Pipeline: 8 register stages.
// Throughput: one pair per cycle; a stalled result at the output freezes all
// stages. Depth is set by the angle test: a*b and d^2, a*b*c^2 as two partial
// products, then the recombine and compare.
// Reset: synchronous, active low; clears stage valids and loads register
// defaults (reach 4.5, cos -0.5, window 1.0 to 1.2 angstrom).
module ch_pi_contact_test #(
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [chpi_pkg::IDX_W-1:0] cfg_index,
  input  logic [chpi_pkg::CFG_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [15:0]    in_carbon_x,
  input  logic signed [15:0]    in_carbon_y,
  input  logic signed [15:0]    in_carbon_z,
  input  logic signed [15:0]    in_hydrogen_x,
  input  logic signed [15:0]    in_hydrogen_y,
  input  logic signed [15:0]    in_hydrogen_z,
  input  logic signed [15:0]    in_centre_x,
  input  logic signed [15:0]    in_centre_y,
  input  logic signed [15:0]    in_centre_z,
  input  logic signed [15:0]    in_axis_x,
  input  logic signed [15:0]    in_axis_y,
  input  logic signed [15:0]    in_axis_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [1:0]            out_verdict
);
  import chpi_pkg::*;

  localparam int NST = 8;
  localparam logic [14:0] REACH_RST = 15'((9 << (COORD_FRAC_BITS - 1)) & 32'h7FFF);
  localparam logic [14:0] WLOW_RST  = 15'((1 << COORD_FRAC_BITS) & 32'h7FFF);
  localparam logic [14:0] WHIGH_RST = 15'((((12 << COORD_FRAC_BITS) + 5) / 10) & 32'h7FFF);

  // configuration registers
  logic [14:0]        reach_r, wlow_r, whigh_r;
  logic signed [15:0] cos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reach_r <= REACH_RST;
      cos_r   <= -16'sd8192;
      wlow_r  <= WLOW_RST;
      whigh_r <= WHIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REACH: reach_r <= cfg_data[14:0];
        REG_COS:   cos_r   <= cfg_data;
        REG_WLOW:  wlow_r  <= cfg_data[14:0];
        REG_WHIGH: whigh_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // global pipeline enable: output register holds when stalled and full
  logic adv;
  logic [NST-1:0] vld_r;
  assign adv      = !(out_stall && vld_r[NST-1]);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NST-2:0], in_valid};
  end

  // ---- stage 1: differences ----
  logic signed [16:0] hc_r [3], hx_r [3], cx_r [3];
  logic signed [15:0] n1_r [3];
  logic signed [15:0] cv [3], hv [3], xv [3], nv [3];
  assign cv = '{in_carbon_x, in_carbon_y, in_carbon_z};
  assign hv = '{in_hydrogen_x, in_hydrogen_y, in_hydrogen_z};
  assign xv = '{in_centre_x, in_centre_y, in_centre_z};
  assign nv = '{in_axis_x, in_axis_y, in_axis_z};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        hc_r[i] <= 17'(cv[i]) - 17'(hv[i]);
        hx_r[i] <= 17'(xv[i]) - 17'(hv[i]);
        cx_r[i] <= 17'(xv[i]) - 17'(cv[i]);
        n1_r[i] <= nv[i];
      end
    end
  end

  // ---- stage 2: products ----
  logic [33:0]        pd_r [3], pa_r [3], pb_r [3];
  logic signed [34:0] pdd_r [3];
  logic signed [33:0] ps_r [3];
  logic signed [16:0] hx2_r [3];
  logic signed [15:0] n2_r [3];
  logic [29:0]        rl2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pd_r[i]  <= 34'(cx_r[i] * cx_r[i]);
        pa_r[i]  <= 34'(hc_r[i] * hc_r[i]);
        pb_r[i]  <= 34'(hx_r[i] * hx_r[i]);
        pdd_r[i] <= 35'(hc_r[i] * hx_r[i]);
        ps_r[i]  <= 34'(hx_r[i] * n1_r[i]);
        hx2_r[i] <= hx_r[i];
        n2_r[i]  <= n1_r[i];
      end
      rl2_r <= 30'(reach_r * reach_r);
    end
  end

  // ---- stage 3: sums and reach test ----
  logic [35:0]        a3_r, b3_r;
  logic signed [36:0] d3_r;
  logic signed [35:0] s3_r;
  logic               far3_r;
  logic signed [16:0] hx3_r [3];
  logic signed [15:0] n3_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      far3_r <= !((36'(pd_r[0]) + 36'(pd_r[1]) + 36'(pd_r[2])) < 36'(rl2_r));
      a3_r   <= 36'(pa_r[0]) + 36'(pa_r[1]) + 36'(pa_r[2]);
      b3_r   <= 36'(pb_r[0]) + 36'(pb_r[1]) + 36'(pb_r[2]);
      d3_r   <= 37'(pdd_r[0]) + 37'(pdd_r[1]) + 37'(pdd_r[2]);
      s3_r   <= 36'(ps_r[0]) + 36'(ps_r[1]) + 36'(ps_r[2]);
      hx3_r  <= hx2_r;
      n3_r   <= n2_r;
    end
  end

  // ---- stage 4: a*b, d^2, c^2, s*n ----
  logic [71:0]        ab4_r, dd4_r;
  logic [30:0]        cc4_r;
  logic signed [36:0] d4_r;
  logic               zero4_r, far4_r;
  logic signed [51:0] sn4_r [3];
  logic signed [16:0] hx4_r [3];
  logic [35:0]        dmag3;
  assign dmag3 = d3_r[36] ? 36'(-d3_r) : 36'(d3_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      ab4_r   <= a3_r * b3_r;
      dd4_r   <= 72'(dmag3) * 72'(dmag3);
      cc4_r   <= 31'(cos_r * cos_r);
      d4_r    <= d3_r;
      zero4_r <= (a3_r == '0) || (b3_r == '0);
      far4_r  <= far3_r;
      for (int i = 0; i < 3; i++) sn4_r[i] <= 52'(s3_r * n3_r[i]);
      hx4_r   <= hx3_r;
    end
  end

  // ---- stage 5: ab*c^2 as two partial products, lhs = dd<<28, offsets ----
  logic [66:0]        rhsl5_r, rhsh5_r;
  logic [103:0]       lhs5_r;
  logic signed [36:0] d5_r;
  logic               zero5_r, far5_r, cneg5_r;
  logic signed [21:0] v5_r [3];
  logic signed [51:0] t4 [3];
  logic signed [23:0] p4 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t4[i] = sn4_r[i] + (52'sd1 <<< (PROJ_SHIFT - 1));
      p4[i] = 24'(t4[i] >>> PROJ_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rhsl5_r <= 67'(ab4_r[35:0]) * 67'(cc4_r);
      rhsh5_r <= 67'(ab4_r[71:36]) * 67'(cc4_r);
      lhs5_r  <= 104'(dd4_r) << PROJ_SHIFT;
      d5_r    <= d4_r;
      zero5_r <= zero4_r;
      far5_r  <= far4_r;
      cneg5_r <= cos_r[15];
      for (int i = 0; i < 3; i++) v5_r[i] <= 22'(25'(hx4_r[i]) - 25'(p4[i]));
    end
  end

  // ---- stage 6: recombine rhs, angle decision, offset squares ----
  logic        ang6_r, far6_r;
  logic [43:0] vv6_r [3];
  logic [103:0] rhs5;
  logic        ang5;
  assign rhs5 = (104'(rhsh5_r) << 36) + 104'(rhsl5_r);

  always_comb begin
    if (zero5_r) ang5 = 1'b0;
    else if (!cneg5_r) ang5 = (d5_r <= 0) || (lhs5_r <= rhs5);
    else ang5 = (d5_r < 0) && (lhs5_r >= rhs5);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang6_r <= ang5;
      far6_r <= far5_r;
      for (int i = 0; i < 3; i++) vv6_r[i] <= 44'(v5_r[i] * v5_r[i]);
    end
  end

  // ---- stage 7: offset sum and window compare ----
  logic     win7_r, ang7_r, far7_r;
  logic [45:0] off6;
  assign off6 = 46'(vv6_r[0]) + 46'(vv6_r[1]) + 46'(vv6_r[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      win7_r <= (off6 >= 46'(wlow_r * wlow_r)) && (off6 <= 46'(whigh_r * whigh_r));
      ang7_r <= ang6_r;
      far7_r <= far6_r;
    end
  end

  // ---- stage 8: verdict output register ----
  verdict_t vd7;
  always_comb begin
    if (far7_r) vd7 = VERDICT_FAR;
    else if (!ang7_r) vd7 = VERDICT_ANGLE;
    else if (!win7_r) vd7 = VERDICT_WINDOW;
    else vd7 = VERDICT_HIT;
  end

  verdict_t vd_r;
  always_ff @(posedge clk) begin
    if (adv) vd_r <= vd7;
  end

  assign out_valid   = vld_r[NST-1];
  assign out_verdict = vd_r;
  assign out_hit     = (vd_r == VERDICT_HIT);

endmodule

FILE: hw/rtl/chpi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chpi_checker
// Port-level checks for the CH-pi contact test, bound to the top level.
// ----------------------------------------------------------------------------
module chpi_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_hit,
  input logic [1:0] out_verdict
);
  import chpi_pkg::*;

  // hit flag agrees with verdict
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit == (out_verdict == VERDICT_HIT)))
    else $error("hit and verdict disagree");

  // input is held off only while a result is stuck at the output
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_verdict)))
    else $error("stalled result changed");

  // nothing comes out of an empty pipe right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind ch_pi_contact_test chpi_checker u_chpi_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
  .out_verdict(out_verdict)
);
